>>> hw/rtl/at_ipd_frame_parser_top_macros.svh
// Assertion helpers for the IPD frame parser. Each macro expects a clock
// named clk and a synchronous reset named rst in the using module.
`ifndef AT_IPD_FRAME_PARSER_TOP_MACROS_SVH
`define AT_IPD_FRAME_PARSER_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ATIPD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ATIPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/atipd_pkg.sv
// ----------------------------------------------------------------------------
// atipd_pkg
// Types and constants shared by the IPD frame parser.
// ----------------------------------------------------------------------------
package atipd_pkg;

  localparam int MAX_PAYLOAD = 1024;
  // Length register holds 0..MAX_PAYLOAD; the trial length needs room for x10+9.
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int NEXT_W = LEN_W + 4;

  localparam logic [7:0]  CH_PLUS  = 8'h2B;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [31:0] IPD_WORD = 32'h4950442C;  // "IPD,"

  localparam logic [1:0]  PREFIX_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_LENGTH = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       length_error;
  } result_t;

endpackage

>>> hw/rtl/at_ipd_frame_parser_top.sv
// ----------------------------------------------------------------------------
// at_ipd_frame_parser_top
// Extracts '+IPD,<len>:<payload>' frames from an AT reply byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while in_stall is low; the parse
// step is combinational logic from the phase and length registers, and a
// result is registered into the output register. A skid register behind it
// lets the parser take one more byte while a result is held by out_stall;
// in_stall rises only once both are full. Payload bytes are
// passed on one per byte, the last one flagged; a malformed or oversized
// length (above MAX_PAYLOAD) gives one error item with a zero byte, while an
// empty or zero length silently drops the frame. Prefix mismatches are
// dropped without rescanning the four prefix bytes.
module at_ipd_frame_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       last_of_frame,
  output logic       length_error
);
  import atipd_pkg::*;

  `include "at_ipd_frame_parser_top_macros.svh"

  phase_t           phase, phase_next;
  logic [23:0]      prefix, prefix_next;
  logic [1:0]       prefix_cnt, prefix_cnt_next;
  logic [LEN_W-1:0] len_acc, len_acc_next;
  logic [LEN_W-1:0] remaining, remaining_next;

  result_t          res, out_reg, skid_reg;
  logic             res_hit;
  logic             skid_valid;
  logic             in_fire, out_fire;

  logic             is_digit;
  logic [NEXT_W-1:0] len_trial;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_fire = out_valid && !out_stall;

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  // len*10 + digit; '0'..'9' carry the digit in the low nibble
  assign len_trial = {1'b0, len_acc, 3'b000} + {3'b000, len_acc, 1'b0}
                   + {{(NEXT_W-4){1'b0}}, rx_byte[3:0]};

  always_comb begin
    phase_next      = phase;
    prefix_next     = prefix;
    prefix_cnt_next = prefix_cnt;
    len_acc_next    = len_acc;
    remaining_next  = remaining;
    res             = '0;
    res_hit         = 1'b0;
    if (in_fire) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == CH_PLUS) begin
            phase_next      = PH_PREFIX;
            prefix_next     = '0;
            prefix_cnt_next = '0;
          end
        end
        PH_PREFIX: begin
          prefix_next     = {prefix[15:0], rx_byte};
          prefix_cnt_next = prefix_cnt + 2'd1;
          if (prefix_cnt == PREFIX_LAST) begin
            prefix_next     = '0;
            prefix_cnt_next = '0;
            len_acc_next    = '0;
            remaining_next  = '0;
            phase_next      = ({prefix, rx_byte} == IPD_WORD) ? PH_LENGTH : PH_HUNT;
          end
        end
        PH_LENGTH: begin
          if (rx_byte == CH_COLON) begin
            len_acc_next = '0;
            if (len_acc == '0) begin
              phase_next = PH_HUNT;
            end else begin
              remaining_next = len_acc;
              phase_next     = PH_DATA;
            end
          end else if (is_digit && (len_trial <= NEXT_W'(MAX_PAYLOAD))) begin
            len_acc_next = len_trial[LEN_W-1:0];
          end else begin
            // bad character or oversized length
            phase_next        = PH_HUNT;
            len_acc_next      = '0;
            res.length_error  = 1'b1;
            res_hit           = 1'b1;
          end
        end
        PH_DATA: begin
          res.payload_byte = rx_byte;
          res_hit          = 1'b1;
          if (remaining <= LEN_W'(1)) begin
            res.last_of_frame = 1'b1;
            remaining_next    = '0;
            phase_next        = PH_HUNT;
          end else begin
            remaining_next = remaining - LEN_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      prefix     <= '0;
      prefix_cnt <= '0;
      len_acc    <= '0;
      remaining  <= '0;
    end else begin
      phase      <= phase_next;
      prefix     <= prefix_next;
      prefix_cnt <= prefix_cnt_next;
      len_acc    <= len_acc_next;
      remaining  <= remaining_next;
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_hit;
      end
    end else if (res_hit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      out_reg <= skid_valid ? skid_reg : res;
    end
    if (!(out_fire || !out_valid) && res_hit) begin
      skid_reg <= res;
    end
  end

  assign payload_byte  = out_reg.payload_byte;
  assign last_of_frame = out_reg.last_of_frame;
  assign length_error  = out_reg.length_error;

  `ATIPD_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid,
    "skid entry held without a valid output")
  `ATIPD_ASSERT_IMP(a_skid_fill_cause, $rose(skid_valid), $past(out_valid && out_stall),
    "skid filled while the output was free")
  `ATIPD_ASSERT_IMP(a_data_has_count, phase == PH_DATA, remaining != '0,
    "data phase with no bytes remaining")
  `ATIPD_ASSERT_IMP(a_error_item_clean, out_valid && length_error,
    (payload_byte == 8'h00) && !last_of_frame, "error item carries payload")
  `ATIPD_ASSERT(a_len_in_range, len_acc <= LEN_W'(MAX_PAYLOAD),
    "length accumulator beyond maximum")

endmodule
